// File: src/prime_gap_varint_query_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prime gap varint query unit
// Shared property forms with a clocked, reset-gated body.
// ----------------------------------------------------------------------------
`ifndef PRIME_GAP_VARINT_QUERY_UNIT_MACROS_SVH
`define PRIME_GAP_VARINT_QUERY_UNIT_MACROS_SVH

// Same-cycle implication
`define PGVQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PGVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pgvq_pkg.sv
// ----------------------------------------------------------------------------
// pgvq_pkg
// Word types and constants of the prime gap varint query unit.
// ----------------------------------------------------------------------------
package pgvq_pkg;

	// Stream byte fields
	localparam logic [7:0] DATA_MASK = 8'h7F;
	localparam logic [7:0] MORE_FLAG = 8'h80;

	// Bit offset steps by one varint digit; bit 6 set means past the word
	localparam logic [6:0] OFF_STEP = 7'd7;
	localparam logic [6:0] OFF_CAP  = 7'd70;

	localparam logic [63:0] PRIME_INIT = 64'd2;

	// Query modes
	localparam logic MODE_NTH   = 1'b0;
	localparam logic MODE_INDEX = 1'b1;

	// Result status codes
	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_EXHAUSTED = 1'b1;

	// Configuration register indexes
	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_TARGET = 1'b1;

	typedef struct packed {
		logic [7:0] gap_byte;
		logic       stream_start;
		logic       stream_end;
	} in_word_t;

	typedef struct packed {
		logic [63:0] answer;
		logic        status;
	} out_word_t;

	// Result handed from the decoder to the output register
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} res_t;

endpackage

// File: src/pgvq_decode.sv
// ----------------------------------------------------------------------------
// pgvq_decode
// Varint gap assembly, running prime and gap count, and the query test.
// ----------------------------------------------------------------------------
`include "prime_gap_varint_query_unit_macros.svh"

module pgvq_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  pgvq_pkg::in_word_t in_word,
	input  logic              mode,
	input  logic [63:0]       target,
	output pgvq_pkg::res_t    res
);

	logic [63:0] prime_q, count_q, partial_q;
	logic [6:0]  offset_q;
	logic        done_q;

	logic [63:0] prime_d, count_d, partial_d;
	logic [6:0]  offset_d;
	logic        done_d;

	logic [63:0] digit, partial_acc, prime_sum, count_inc;
	logic [6:0]  offset_acc;
	logic        gap_done, met;

	// Digit placement and gap completion
	always_comb begin
		digit       = {56'd0, in_word.gap_byte & pgvq_pkg::DATA_MASK};
		partial_acc = offset_q[6] ? partial_q : (partial_q | (digit << offset_q[5:0]));
		offset_acc  = offset_q[6] ? offset_q : (offset_q + pgvq_pkg::OFF_STEP);
		gap_done    = ~|(in_word.gap_byte & pgvq_pkg::MORE_FLAG);
		prime_sum   = prime_q + partial_acc;
		count_inc   = count_q + 64'd1;
		met         = (mode == pgvq_pkg::MODE_INDEX) ? (prime_sum >= target)
		                                             : (count_inc >= target);
	end

	// Next state and result
	always_comb begin
		prime_d   = prime_q;
		count_d   = count_q;
		partial_d = partial_q;
		offset_d  = offset_q;
		done_d    = done_q;
		res       = '0;
		if (in_word.stream_start) begin
			prime_d   = pgvq_pkg::PRIME_INIT;
			count_d   = '0;
			partial_d = '0;
			offset_d  = '0;
			done_d    = 1'b0;
			if ((mode == pgvq_pkg::MODE_INDEX) ? (target <= pgvq_pkg::PRIME_INIT)
			                                   : (target == 64'd0)) begin
				res.valid       = 1'b1;
				res.word.answer = (mode == pgvq_pkg::MODE_INDEX) ? 64'd0
				                                                 : pgvq_pkg::PRIME_INIT;
				res.word.status = pgvq_pkg::STATUS_FOUND;
				done_d          = 1'b1;
			end else if (in_word.stream_end) begin
				res.valid       = 1'b1;
				res.word.status = pgvq_pkg::STATUS_EXHAUSTED;
				done_d          = 1'b1;
			end
		end else if (!done_q) begin
			partial_d = partial_acc;
			offset_d  = offset_acc;
			if (gap_done) begin
				prime_d   = prime_sum;
				count_d   = count_inc;
				partial_d = '0;
				offset_d  = '0;
			end
			if (gap_done && met) begin
				res.valid       = 1'b1;
				res.word.answer = (mode == pgvq_pkg::MODE_INDEX) ? count_inc : prime_sum;
				res.word.status = pgvq_pkg::STATUS_FOUND;
				done_d          = 1'b1;
			end else if (in_word.stream_end) begin
				res.valid       = 1'b1;
				res.word.status = pgvq_pkg::STATUS_EXHAUSTED;
				done_d          = 1'b1;
			end
		end
	end

	// Query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q   <= pgvq_pkg::PRIME_INIT;
			count_q   <= '0;
			partial_q <= '0;
			offset_q  <= '0;
			done_q    <= 1'b0;
		end else if (take) begin
			prime_q   <= prime_d;
			count_q   <= count_d;
			partial_q <= partial_d;
			offset_q  <= offset_d;
			done_q    <= done_d;
		end
	end

	`PGVQ_ASSERT_NOW(a_quiet_after_answer, clk, arst_n,
		take && !in_word.stream_start && done_q, !res.valid,
		"result after query already answered")
	`PGVQ_ASSERT_NEXT(a_end_closes_query, clk, arst_n,
		take && in_word.stream_end, done_q,
		"query still open after stream end")
	`PGVQ_ASSERT_NOW(a_offset_range, clk, arst_n,
		1'b1, !offset_q[6] || offset_q == pgvq_pkg::OFF_CAP,
		"bit offset out of range")

endmodule

// File: src/pgvq_out_reg.sv
// ----------------------------------------------------------------------------
// pgvq_out_reg
// Result register; holds a word until the consumer takes it.
// ----------------------------------------------------------------------------
`include "prime_gap_varint_query_unit_macros.svh"

module pgvq_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pgvq_pkg::res_t     res,
	output logic               out_valid,
	input  logic               out_ready,
	output pgvq_pkg::out_word_t out_word
);

	logic                valid_q;
	pgvq_pkg::out_word_t word_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			word_q <= res.word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

	`PGVQ_ASSERT_NOW(a_no_overwrite, clk, arst_n,
		valid_q && !out_ready, !load,
		"new word loaded over a stalled result")

endmodule

// File: src/prime_gap_varint_query_unit.sv
// ----------------------------------------------------------------------------
// prime_gap_varint_query_unit
// Decodes a stream of base-128 varint prime gaps, one byte per cycle while
// in_ready is high, and answers either the prime after query_target gaps
// (query_mode 0) or the gap count at which the running prime first reaches
// query_target (query_mode 1). Every accepted byte is handled in the cycle
// it is taken: one 64-bit shift and OR, two 64-bit adds (prime and count)
// and a 64-bit compare close the loop through the query state; a result is
// registered in the cycle after the byte that caused it. in_ready drops
// only while a result sits in the output register and out_ready is low. A
// stream that runs out first gives status 1 with answer 0. Write query_mode
// (index 0) and query_target (index 1) only while no query is in flight.
// ----------------------------------------------------------------------------
module prime_gap_varint_query_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pgvq_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output pgvq_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [63:0]         cfg_wdata
);

	logic           mode_q;
	logic [63:0]    target_q;
	logic           in_fire;
	pgvq_pkg::res_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= pgvq_pkg::MODE_NTH;
			target_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgvq_pkg::CFG_MODE:   mode_q   <= cfg_wdata[0];
				pgvq_pkg::CFG_TARGET: target_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Take a byte whenever the result slot is free or draining
	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	pgvq_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_fire),
		.in_word (in_word),
		.mode    (mode_q),
		.target  (target_q),
		.res     (res)
	);

	pgvq_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
